>>> rtl/tbd4_pkg.sv
// Shared types, constants and decode functions for the 4bpp texture block decoder.
package tbd4_pkg;

  localparam int unsigned BLK       = 4;
  localparam int unsigned ROW_W     = 2;
  localparam int unsigned TEXEL_W   = 32;
  localparam int unsigned LANES     = 4;

  // 5-bit RGB plus 4-bit alpha for one endpoint color
  typedef struct packed {
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    logic [3:0] a;
  } color_t;

  // Per-row work handed to the lanes
  typedef struct packed {
    logic [3:0][31:0] mods;
    logic [3:0]       punch_mode;
    color_t [3:0]     ca;
    color_t [3:0]     cb;
    logic [ROW_W-1:0] row;
  } row_job_t;

  function automatic color_t decode_a(input logic [31:0] cd);
    color_t c;
    if (cd[15]) begin
      c.r = cd[14:10];
      c.g = cd[9:5];
      c.b = {cd[4:1], cd[4]};
      c.a = 4'hf;
    end else begin
      c.r = {cd[11:8], cd[11]};
      c.g = {cd[7:4], cd[7]};
      c.b = {cd[3:1], cd[3:2]};
      c.a = {cd[14:12], 1'b0};
    end
    return c;
  endfunction

  function automatic color_t decode_b(input logic [31:0] cd);
    color_t c;
    if (cd[31]) begin
      c.r = cd[30:26];
      c.g = cd[25:21];
      c.b = cd[20:16];
      c.a = 4'hf;
    end else begin
      c.r = {cd[27:24], cd[27]};
      c.g = {cd[23:20], cd[23]};
      c.b = {cd[19:16], cd[19]};
      c.a = {cd[30:28], 1'b0};
    end
    return c;
  endfunction

  // Bilinear upscale of one channel; weights y,x in 0..3, sum fits in 9 bits (x16)
  function automatic logic [7:0] upscale(input logic [4:0] p, input logic [4:0] q,
                                         input logic [4:0] r, input logic [4:0] s,
                                         input logic [1:0] y, input logic [1:0] x,
                                         input logic alpha);
    logic [7:0]  top;
    logic [7:0]  bot;
    logic [10:0] v;
    logic [10:0] sum;
    top = 8'(({1'b0, 3'd4} - {2'b0, y}) * p) + 8'(y * q);
    bot = 8'(({1'b0, 3'd4} - {2'b0, y}) * r) + 8'(y * s);
    v   = 11'(({1'b0, 3'd4} - {2'b0, x}) * top) + 11'(x * bot);
    if (alpha) sum = (v >> 4) + v;
    else       sum = (v >> 6) + (v >> 1);
    return sum[7:0];
  endfunction

endpackage

>>> rtl/tbd4_lane.sv
// One texel lane: upscale, modulation weight and blend for one column of a row.
module tbd4_lane
  import tbd4_pkg::*;
#(
  parameter int unsigned COL = 0
) (
  input  logic             clk,
  input  logic             load,
  input  row_job_t         job,
  output logic [31:0]      texel
);

  logic [1:0] mrow;
  logic [1:0] mcol;
  logic [1:0] blk;
  logic [1:0] code;
  logic [3:0] w;
  logic       punch;
  logic       pt_mode;
  logic [31:0] mword;
  logic [31:0] texel_next;

  // modulation grid position row+2, col+2
  always_comb begin
    logic [2:0] gr;
    logic [2:0] gc;
    gr = {1'b0, job.row} + 3'd2;
    gc = 3'(COL) + 3'd2;
    mrow = gr[1:0];
    mcol = gc[1:0];
    blk = {gr[2], gc[2]};
    mword = job.mods[blk];
    pt_mode = job.punch_mode[blk];
    code = mword[{mrow, mcol, 1'b0} +: 2];
  end

  // weight lookup
  always_comb begin
    punch = 1'b0;
    if (pt_mode) begin
      case (code)
        2'd0: w = 4'd0;
        2'd1: w = 4'd4;
        2'd2: begin w = 4'd4; punch = 1'b1; end
        default: w = 4'd8;
      endcase
    end else begin
      case (code)
        2'd0: w = 4'd0;
        2'd1: w = 4'd3;
        2'd2: w = 4'd5;
        default: w = 4'd8;
      endcase
    end
  end

  // per-channel upscale and blend; colors indexed at grid (y=COL, x=row)
  always_comb begin
    logic [7:0]  a;
    logic [7:0]  b;
    logic [11:0] v;
    texel_next = '0;
    for (int ch = 0; ch < 4; ch++) begin
      case (ch)
        0: begin
          a = upscale(job.ca[0].r, job.ca[1].r, job.ca[2].r, job.ca[3].r,
                      2'(COL), job.row, 1'b0);
          b = upscale(job.cb[0].r, job.cb[1].r, job.cb[2].r, job.cb[3].r,
                      2'(COL), job.row, 1'b0);
        end
        1: begin
          a = upscale(job.ca[0].g, job.ca[1].g, job.ca[2].g, job.ca[3].g,
                      2'(COL), job.row, 1'b0);
          b = upscale(job.cb[0].g, job.cb[1].g, job.cb[2].g, job.cb[3].g,
                      2'(COL), job.row, 1'b0);
        end
        2: begin
          a = upscale(job.ca[0].b, job.ca[1].b, job.ca[2].b, job.ca[3].b,
                      2'(COL), job.row, 1'b0);
          b = upscale(job.cb[0].b, job.cb[1].b, job.cb[2].b, job.cb[3].b,
                      2'(COL), job.row, 1'b0);
        end
        default: begin
          a = upscale({1'b0, job.ca[0].a}, {1'b0, job.ca[1].a}, {1'b0, job.ca[2].a},
                      {1'b0, job.ca[3].a}, 2'(COL), job.row, 1'b1);
          b = upscale({1'b0, job.cb[0].a}, {1'b0, job.cb[1].a}, {1'b0, job.cb[2].a},
                      {1'b0, job.cb[3].a}, 2'(COL), job.row, 1'b1);
        end
      endcase
      v = 12'(a * (4'd8 - w)) + 12'(b * w);
      if (ch == 3 && punch) v = '0;
      texel_next[8*ch +: 8] = v[10:3];
    end
  end

  always_ff @(posedge clk) begin
    if (load) texel <= texel_next;
  end

endmodule

>>> rtl/texture_block_decoder_4bpp_unit.sv
// The input transfer registers the held item; each row is then registered in the lanes and the output register.
// While out_stall is low, rows follow one per cycle; the four output rows of a block neighbourhood
// share the four-lane row datapath.
// Reset (rst, synchronous): drops held item and output valid; payload not cleared.
// Next item is accepted at the edge that loads the last row, so blocks stream back to back.
module texture_block_decoder_4bpp_unit
  import tbd4_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] p_mod,
  input  logic [31:0] p_color,
  input  logic [31:0] q_mod,
  input  logic [31:0] q_color,
  input  logic [31:0] r_mod,
  input  logic [31:0] r_color,
  input  logic [31:0] s_mod,
  input  logic [31:0] s_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] texel_0,
  output logic [31:0] texel_1,
  output logic [31:0] texel_2,
  output logic [31:0] texel_3,
  output logic [1:0]  row_index,
  output logic        last_row
);

  // held item: decoded colors and modulation words
  logic          busy;
  logic [ROW_W-1:0] row;
  row_job_t      job;
  logic [3:0][31:0] mods;
  logic [3:0]    pmode;
  color_t [3:0]  ca;
  color_t [3:0]  cb;
  logic          load;
  logic          adv;
  logic          in_xfer;
  logic [3:0][31:0] lane_out;

  assign load    = busy && (!out_valid || !out_stall);
  assign adv     = load;
  assign in_stall = busy && !(adv && row == 2'd3);
  assign in_xfer = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mods  <= {s_mod, r_mod, q_mod, p_mod};
      pmode <= {s_color[0], r_color[0], q_color[0], p_color[0]};
      ca    <= {decode_a(s_color), decode_a(r_color), decode_a(q_color), decode_a(p_color)};
      cb    <= {decode_b(s_color), decode_b(r_color), decode_b(q_color), decode_b(p_color)};
    end
  end

  // row sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= '0;
    end else begin
      if (in_xfer) begin
        busy <= 1'b1;
        row  <= '0;
      end else if (adv) begin
        row <= row + 2'd1;
        if (row == 2'd3) busy <= 1'b0;
      end
    end
  end

  always_comb begin
    job.mods       = mods;
    job.punch_mode = pmode;
    job.ca         = ca;
    job.cb         = cb;
    job.row        = row;
  end

  // four texel lanes
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    tbd4_lane #(.COL(l)) u_lane (
      .clk  (clk),
      .load (load),
      .job  (job),
      .texel(lane_out[l])
    );
  end

  // output register merges lane results with row tag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_index <= row;
      last_row  <= (row == 2'd3);
    end
  end

  assign texel_0 = lane_out[0];
  assign texel_1 = lane_out[1];
  assign texel_2 = lane_out[2];
  assign texel_3 = lane_out[3];

endmodule

>>> rtl/tbd4_checker.sv
// Port-level checker for the texture block decoder, bound to the top level.
module tbd4_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] row_index,
  input logic       last_row
);

  a_last_tag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_row == (row_index == 2'd3)))
    else $error("last_row does not match row_index");

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last_row) ##1 out_valid |->
      row_index == $past(row_index) + 2'd1)
    else $error("rows out of order");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(row_index)))
    else $error("stalled row changed");

  a_no_accept_mid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_row && out_stall) |-> in_stall)
    else $error("input accepted mid block");

endmodule

bind texture_block_decoder_4bpp_unit tbd4_checker u_tbd4_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .row_index(row_index), .last_row(last_row)
);

>>> sim/texture_block_decoder_4bpp_unit_test.sv
// Testbench for the 4bpp texture block decoder: random and directed neighbourhoods checked row by row.
module texture_block_decoder_4bpp_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] w [8];  // p_mod, p_color, q_mod, q_color, r_mod, r_color, s_mod, s_color
  } hood_t;

  typedef struct {
    logic [31:0] texel [4];
    logic [1:0]  row;
    logic        last;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] p_mod = '0, p_color = '0, q_mod = '0, q_color = '0;
  logic [31:0] r_mod = '0, r_color = '0, s_mod = '0, s_color = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] texel_0, texel_1, texel_2, texel_3;
  logic [1:0]  row_index;
  logic        last_row;

  hood_t pending_hoods [$];
  row_t  expected_rows [$];
  int    errors = 0;
  int    cycle = 0;
  int    hold_left = 0;
  bit    hold_done = 1'b0;

  texture_block_decoder_4bpp_unit i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Endpoint colors widened to 5-bit RGB and 4-bit alpha
  function automatic void decode_endpoints(input logic [31:0] cd,
                                           output int ca [4], output int cb [4]);
    if (cd[15]) begin
      ca[0] = cd[14:10];
      ca[1] = cd[9:5];
      ca[2] = {cd[4:1], cd[4]};
      ca[3] = 15;
    end else begin
      ca[0] = {cd[11:8], cd[11]};
      ca[1] = {cd[7:4], cd[7]};
      ca[2] = {cd[3:1], cd[3:2]};
      ca[3] = {cd[14:12], 1'b0};
    end
    if (cd[31]) begin
      cb[0] = cd[30:26];
      cb[1] = cd[25:21];
      cb[2] = cd[20:16];
      cb[3] = 15;
    end else begin
      cb[0] = {cd[27:24], cd[27]};
      cb[1] = {cd[23:20], cd[23]};
      cb[2] = {cd[19:16], cd[19]};
      cb[3] = {cd[30:28], 1'b0};
    end
  endfunction

  function automatic int bilinear(input int c [4], input int y, input int x, input bit alpha);
    int top, bot, v;
    top = (4 - y) * c[0] + y * c[1];
    bot = (4 - y) * c[2] + y * c[3];
    v   = (4 - x) * top + x * bot;
    return alpha ? (((v >> 4) + v) & 255) : (((v >> 6) + (v >> 1)) & 255);
  endfunction

  // Four output rows of one neighbourhood, in transposed order
  task automatic predict_rows(input hood_t h);
    int   ca [4][4], cb [4][4];
    int   chan_a [4], chan_b [4];
    int   mrow, mcol, blk, code, wt, a, b, v;
    bit   punch;
    row_t r;
    for (int i = 0; i < 4; i++) decode_endpoints(h.w[2*i+1], ca[i], cb[i]);
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        mrow = k + 2;
        mcol = j + 2;
        blk  = ((mrow >> 2) & 1) * 2 + ((mcol >> 2) & 1);
        code = (h.w[2*blk] >> (2 * ((mrow & 3) * 4 + (mcol & 3)))) & 3;
        punch = 1'b0;
        if (h.w[2*blk+1][0]) begin
          wt = (code == 0) ? 0 : (code == 3) ? 8 : 4;
          punch = (code == 2);
        end else begin
          wt = (code == 0) ? 0 : (code == 1) ? 3 : (code == 2) ? 5 : 8;
        end
        r.texel[j] = '0;
        for (int ch = 0; ch < 4; ch++) begin
          for (int n = 0; n < 4; n++) begin
            chan_a[n] = ca[n][ch];
            chan_b[n] = cb[n][ch];
          end
          a = bilinear(chan_a, j, k, ch == 3);
          b = bilinear(chan_b, j, k, ch == 3);
          v = (a * (8 - wt) + b * wt) / 8;
          if (ch == 3 && punch) v = 0;
          r.texel[j][8*ch +: 8] = v[7:0];
        end
      end
      r.row  = k[1:0];
      r.last = (k == 3);
      expected_rows.push_back(r);
    end
  endtask

  function automatic bit idle_now();
    // no idling in the middle stretch of the run
    if (cycle > 1500 && cycle < 2500) return 1'b0;
    return $urandom_range(99) < 38;
  endfunction

  // Sender: present the next neighbourhood once the current one is taken
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst) begin
      if (in_valid && !in_stall)
        predict_rows('{w: '{p_mod, p_color, q_mod, q_color, r_mod, r_color, s_mod, s_color}});
      if (!in_valid || !in_stall) begin
        if (pending_hoods.size() > 0 && !idle_now()) begin
          hood_t h;
          h = pending_hoods.pop_front();
          {p_mod, p_color, q_mod, q_color} <= {h.w[0], h.w[1], h.w[2], h.w[3]};
          {r_mod, r_color, s_mod, s_color} <= {h.w[4], h.w[5], h.w[6], h.w[7]};
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, row checks
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          errors++;
          $display("%0t: unexpected row %0d", $time, row_index);
        end else begin
          row_t e;
          logic [31:0] got [4];
          e = expected_rows.pop_front();
          got = '{texel_0, texel_1, texel_2, texel_3};
          for (int j = 0; j < 4; j++)
            if (got[j] !== e.texel[j]) begin
              errors++;
              $display("%0t: row %0d texel_%0d expected %h actual %h",
                       $time, e.row, j, e.texel[j], got[j]);
            end
          if (row_index !== e.row) begin
            errors++;
            $display("%0t: row_index expected %0d actual %0d", $time, e.row, row_index);
          end
          if (last_row !== e.last) begin
            errors++;
            $display("%0t: last_row expected %0b actual %0b", $time, e.last, last_row);
          end
        end
      end
      if (!hold_done && cycle > 800) begin
        hold_left <= 80;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_now();
      end
    end
  end

  initial begin
    hood_t h;
    logic [31:0] mods [4];
    logic [31:0] cols [6];
    mods = '{32'h0, 32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff};
    cols = '{32'h0, 32'hffff_ffff, 32'h8000_8000, 32'h7fff_7ffe,
             32'h8000_0001, 32'h7fff_ffff};
    // directed: modulation codes against color formats and both modes
    foreach (cols[c])
      foreach (mods[m]) begin
        for (int i = 0; i < 4; i++) begin
          h.w[2*i]   = mods[m];
          h.w[2*i+1] = cols[c] ^ (i == 2 ? 32'h1 : 32'h0);
        end
        pending_hoods.push_back(h);
      end
    // random: mixed modes and formats
    for (int n = 0; n < 356; n++) begin
      for (int i = 0; i < 8; i++) h.w[i] = $urandom;
      pending_hoods.push_back(h);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (pending_hoods.size() > 0 || in_valid) @(posedge clk);
    while (expected_rows.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
